// ===== rtl/core/script_line_lexer_assert.svh =====
// Assertion macros for the checker file of the script line lexer.
`ifndef SCRIPT_LINE_LEXER_ASSERT_SVH
`define SCRIPT_LINE_LEXER_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define SLX_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("script line lexer assertion failed");

// Next-cycle implication, sampled on clk and switched off during rst.
`define SLX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("script line lexer assertion failed");

`endif

// ===== rtl/core/slx_pkg.sv =====
// Package of types, codes and character tables for the script line lexer.
`default_nettype none

package slx_pkg;

  // Lexer modes held by the front part.
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_EQ   = 3'd1,
    MODE_DQ   = 3'd2,
    MODE_SQ   = 3'd3,
    MODE_WORD = 3'd4
  } mode_t;

  // Record kinds.
  localparam logic REC_VALUE = 1'b0;
  localparam logic REC_TOKEN = 1'b1;

  // Token kinds.
  localparam logic [3:0] TK_LPAREN  = 4'd0;
  localparam logic [3:0] TK_RPAREN  = 4'd1;
  localparam logic [3:0] TK_EQEQ    = 4'd2;
  localparam logic [3:0] TK_STRING  = 4'd3;
  localparam logic [3:0] TK_NUMBER  = 4'd4;
  localparam logic [3:0] TK_NAME    = 4'd5;
  localparam logic [3:0] TK_PRINT   = 4'd6;
  localparam logic [3:0] TK_IF      = 4'd7;
  localparam logic [3:0] TK_END     = 4'd8;
  localparam logic [3:0] TK_EOF     = 4'd9;
  localparam logic [3:0] TK_UNKNOWN = 4'd10;

  // Keyword candidates.
  localparam logic [1:0] KW_NONE  = 2'd0;
  localparam logic [1:0] KW_PRINT = 2'd1;
  localparam logic [1:0] KW_IF    = 2'd2;
  localparam logic [1:0] KW_END   = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_D   = 8'h64;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_I   = 8'h69;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_P   = 8'h70;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;

  // One queued command: every result that one item causes, in emission order.
  typedef struct packed {
    logic       pre_unk;    // unknown token for a lone equals sign
    logic       esc_v;      // character released by a pending backslash
    logic       esc_nl;     // that character is a newline, else a backslash
    logic [1:0] flush_kw;   // keyword whose held prefix is released
    logic [2:0] flush_n;    // number of held characters to release
    logic       val_v;
    logic [3:0] val_kind;
    logic [7:0] val_char;
    logic       tok1_v;
    logic [3:0] tok1_kind;
    logic       tok2_v;
    logic [3:0] tok2_kind;
  } cmd_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic ends_word(input logic [7:0] c);
    return (c == CH_NUL) || is_space(c) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

  function automatic logic [1:0] start_kw(input logic [7:0] c);
    logic [1:0] kw;
    case (c)
      CH_LC_P: kw = KW_PRINT;
      CH_LC_I: kw = KW_IF;
      CH_LC_E: kw = KW_END;
      default: kw = KW_NONE;
    endcase
    return kw;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] kw);
    logic [2:0] n;
    case (kw)
      KW_PRINT: n = 3'd5;
      KW_IF:    n = 3'd2;
      KW_END:   n = 3'd3;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] kw_kind(input logic [1:0] kw);
    logic [3:0] k;
    case (kw)
      KW_PRINT: k = TK_PRINT;
      KW_IF:    k = TK_IF;
      KW_END:   k = TK_END;
      default:  k = TK_NAME;
    endcase
    return k;
  endfunction

  // Character at a position of a keyword's spelling.
  function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] idx);
    logic [7:0] ch;
    ch = CH_NUL;
    case (kw)
      KW_PRINT: begin
        case (idx)
          3'd0:    ch = CH_LC_P;
          3'd1:    ch = CH_LC_R;
          3'd2:    ch = CH_LC_I;
          3'd3:    ch = CH_LC_N;
          3'd4:    ch = CH_LC_T;
          default: ch = CH_NUL;
        endcase
      end
      KW_IF: begin
        case (idx)
          3'd0:    ch = CH_LC_I;
          3'd1:    ch = CH_LC_F;
          default: ch = CH_NUL;
        endcase
      end
      KW_END: begin
        case (idx)
          3'd0:    ch = CH_LC_E;
          3'd1:    ch = CH_LC_N;
          3'd2:    ch = CH_LC_D;
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slx_front.sv =====
// Front part of the script line lexer: lexer state and classification of each item.
`default_nettype none

module slx_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          char_valid,
  input  wire logic [7:0]    char_code,
  output logic               char_stall,
  input  wire logic          room,
  output logic               push,
  output slx_pkg::cmd_t      cmd
);
  import slx_pkg::*;

  typedef struct packed {
    logic       tok_v;
    logic [3:0] tok_k;
    logic       val_v;
    logic [3:0] val_k;
    mode_t      mode;
    logic [1:0] kw;
    logic [2:0] held;
    logic       digits;
  } start_t;

  mode_t      mode, mode_next;
  logic       esc, esc_next;
  logic [1:0] kw, kw_next;
  logic [2:0] held, held_next;
  logic       digits, digits_next;
  logic       accept;
  start_t     st;

  // Effect of a character met between tokens.
  function automatic start_t start_eff(input logic [7:0] c);
    start_t s;
    s = '0;
    s.mode = MODE_IDLE;
    s.kw = KW_NONE;
    s.digits = 1'b1;
    if (c == CH_NUL) begin
      s.tok_v = 1'b1;
      s.tok_k = TK_EOF;
    end else if (!is_space(c)) begin
      case (c)
        CH_LPAREN: begin
          s.tok_v = 1'b1;
          s.tok_k = TK_LPAREN;
        end
        CH_RPAREN: begin
          s.tok_v = 1'b1;
          s.tok_k = TK_RPAREN;
        end
        CH_EQ:     s.mode = MODE_EQ;
        CH_DQUOTE: s.mode = MODE_DQ;
        CH_SQUOTE: s.mode = MODE_SQ;
        default: begin
          s.mode = MODE_WORD;
          s.digits = is_digit(c);
          s.kw = start_kw(c);
          s.held = (s.kw != KW_NONE) ? 3'd1 : 3'd0;
          s.val_v = (s.kw == KW_NONE);
          s.val_k = is_digit(c) ? TK_NUMBER : TK_NAME;
        end
      endcase
    end
    return s;
  endfunction

  assign accept     = char_valid && room;
  assign char_stall = !room;
  assign push = accept && (cmd.pre_unk || cmd.esc_v || (cmd.flush_n != 3'd0) ||
                           cmd.val_v || cmd.tok1_v || cmd.tok2_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      esc    <= 1'b0;
      kw     <= KW_NONE;
      held   <= 3'd0;
      digits <= 1'b1;
    end else if (accept) begin
      mode   <= mode_next;
      esc    <= esc_next;
      kw     <= kw_next;
      held   <= held_next;
      digits <= digits_next;
    end
  end

  always_comb begin
    logic [7:0] quote;
    logic       dig;
    st          = start_eff(char_code);
    quote       = (mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE;
    dig         = digits && is_digit(char_code);
    mode_next   = mode;
    esc_next    = 1'b0;
    kw_next     = kw;
    held_next   = held;
    digits_next = digits;
    cmd         = '0;
    cmd.val_char = char_code;
    case (mode)
      MODE_EQ: begin
        if (char_code == CH_EQ) begin
          cmd.tok1_v    = 1'b1;
          cmd.tok1_kind = TK_EQEQ;
          mode_next     = MODE_IDLE;
        end else begin
          cmd.pre_unk   = 1'b1;
          cmd.tok1_v    = st.tok_v;
          cmd.tok1_kind = st.tok_k;
          cmd.val_v     = st.val_v;
          cmd.val_kind  = st.val_k;
          mode_next     = st.mode;
          kw_next       = st.kw;
          held_next     = st.held;
          digits_next   = st.digits;
        end
      end
      MODE_DQ, MODE_SQ: begin
        cmd.esc_v  = esc;
        cmd.esc_nl = esc && (char_code == CH_LC_N);
        if (!(esc && (char_code == CH_LC_N))) begin
          if (char_code == CH_NUL) begin
            cmd.tok1_v    = 1'b1;
            cmd.tok1_kind = TK_STRING;
            cmd.tok2_v    = 1'b1;
            cmd.tok2_kind = TK_EOF;
            mode_next     = MODE_IDLE;
          end else if (char_code == quote) begin
            cmd.tok1_v    = 1'b1;
            cmd.tok1_kind = TK_STRING;
            mode_next     = MODE_IDLE;
          end else if (char_code == CH_BSLASH) begin
            esc_next = 1'b1;
          end else begin
            cmd.val_v    = 1'b1;
            cmd.val_kind = TK_STRING;
          end
        end
      end
      MODE_WORD: begin
        if (ends_word(char_code)) begin
          cmd.tok1_v = 1'b1;
          if (kw != KW_NONE) begin
            if (held == kw_len(kw)) begin
              cmd.tok1_kind = kw_kind(kw);
            end else begin
              cmd.flush_kw  = kw;
              cmd.flush_n   = held;
              cmd.tok1_kind = TK_NAME;
            end
          end else begin
            cmd.tok1_kind = digits ? TK_NUMBER : TK_NAME;
          end
          // The ending character may itself be a token or open a string.
          cmd.tok2_v    = st.tok_v;
          cmd.tok2_kind = st.tok_k;
          mode_next     = st.mode;
          kw_next       = KW_NONE;
          held_next     = 3'd0;
          digits_next   = 1'b1;
        end else begin
          digits_next = dig;
          if ((kw != KW_NONE) && (held < kw_len(kw)) && (kw_char(kw, held) == char_code)) begin
            held_next = held + 3'd1;
          end else begin
            if (kw != KW_NONE) begin
              cmd.flush_kw = kw;
              cmd.flush_n  = held;
              kw_next      = KW_NONE;
              held_next    = 3'd0;
            end
            cmd.val_v    = 1'b1;
            cmd.val_kind = dig ? TK_NUMBER : TK_NAME;
          end
        end
      end
      default: begin
        cmd.tok1_v    = st.tok_v;
        cmd.tok1_kind = st.tok_k;
        cmd.val_v     = st.val_v;
        cmd.val_kind  = st.val_k;
        mode_next     = st.mode;
        kw_next       = st.kw;
        held_next     = st.held;
        digits_next   = st.digits;
      end
    endcase
    // The line end returns every state entry to its reset value.
    if (char_code == CH_NUL) begin
      mode_next   = MODE_IDLE;
      esc_next    = 1'b0;
      kw_next     = KW_NONE;
      held_next   = 3'd0;
      digits_next = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/slx_queue.sv =====
// Command queue between the front and back parts of the script line lexer.
`default_nettype none

module slx_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire slx_pkg::cmd_t push_data,
  input  wire logic          pop,
  output slx_pkg::cmd_t      head,
  output logic               room,
  output logic               not_empty
);
  import slx_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head      = entries[rd_ptr];
  assign room      = (count != CW'(DEPTH));
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/slx_back.sv =====
// Back part of the script line lexer: serialises each command into result items.
`default_nettype none

module slx_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire slx_pkg::cmd_t head,
  input  wire logic          not_empty,
  output logic               pop,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic               record_kind,
  output logic [3:0]         token_kind,
  output logic [7:0]         value_char,
  output logic               last_of_run
);
  import slx_pkg::*;

  cmd_t       cur, rem;
  logic       cur_valid;
  logic [2:0] pos, pos_next;
  logic       advance, last;
  logic       o_rk;
  logic [3:0] o_tk;
  logic [7:0] o_ch;

  // Pick the first outstanding result of the current command.
  always_comb begin
    rem      = cur;
    pos_next = pos;
    o_rk     = REC_TOKEN;
    o_tk     = TK_NAME;
    o_ch     = CH_NUL;
    if (cur.pre_unk) begin
      o_tk        = TK_UNKNOWN;
      rem.pre_unk = 1'b0;
    end else if (cur.esc_v) begin
      o_rk      = REC_VALUE;
      o_tk      = TK_STRING;
      o_ch      = cur.esc_nl ? CH_LF : CH_BSLASH;
      rem.esc_v = 1'b0;
    end else if (pos != cur.flush_n) begin
      o_rk     = REC_VALUE;
      o_tk     = TK_NAME;
      o_ch     = kw_char(cur.flush_kw, pos);
      pos_next = pos + 3'd1;
    end else if (cur.val_v) begin
      o_rk      = REC_VALUE;
      o_tk      = cur.val_kind;
      o_ch      = cur.val_char;
      rem.val_v = 1'b0;
    end else if (cur.tok1_v) begin
      o_tk       = cur.tok1_kind;
      rem.tok1_v = 1'b0;
    end else begin
      o_tk       = cur.tok2_kind;
      rem.tok2_v = 1'b0;
    end
    last = !(rem.pre_unk || rem.esc_v || (pos_next != cur.flush_n) ||
             rem.val_v || rem.tok1_v || rem.tok2_v);
  end

  assign advance = cur_valid && (!result_valid || !result_stall);
  assign pop     = not_empty && (!cur_valid || (advance && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (advance && last) begin
        cur_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      pos <= 3'd0;
    end else if (advance) begin
      cur <= rem;
      pos <= pos_next;
    end
    if (advance) begin
      record_kind <= o_rk;
      token_kind  <= o_tk;
      value_char  <= o_ch;
      last_of_run <= last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/script_line_lexer.sv =====
// Top level of the script line lexer: front part, command queue and back part.
//
//   Channel  Handshake                    Fields
//   char     char_valid / char_stall      char_code
//   result   result_valid / result_stall  record_kind, token_kind, value_char,
//                                         last_of_run
//
// Each cycle the front part takes one character item while the command queue has room.
// The back part sends one result item per cycle unless a result stall holds the output;
// a character causing n results (one to six) keeps it busy until all n are out; whitespace
// and held keyword letters cause none.
// Reset is synchronous and clears the lexer state, the queue and the output valid flag.
// A result stall holds the output register, then fills the queue, then raises char_stall.
`default_nettype none

module script_line_lexer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_stall,
  input  wire logic [7:0] char_code,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic            record_kind,
  output logic [3:0]      token_kind,
  output logic [7:0]      value_char,
  output logic            last_of_run
);
  import slx_pkg::*;

  // Commands carry every result of one item, so the back part never needs to
  // look at the lexer state; the queue lets a burst of results drain while the
  // front part keeps taking characters.
  cmd_t front_cmd, head_cmd;
  logic push, pop, room, not_empty;

  slx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_code  (char_code),
    .char_stall (char_stall),
    .room       (room),
    .push       (push),
    .cmd        (front_cmd)
  );

  slx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .pop       (pop),
    .head      (head_cmd),
    .room      (room),
    .not_empty (not_empty)
  );

  // The back part ends in a registered output stage, so the front part keeps
  // pushing into the queue while an earlier result still waits to be taken.
  slx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head_cmd),
    .not_empty    (not_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .record_kind  (record_kind),
    .token_kind   (token_kind),
    .value_char   (value_char),
    .last_of_run  (last_of_run)
  );

endmodule

`default_nettype wire

// ===== rtl/core/slx_checker.sv =====
// Port-level checker for the script line lexer and its bind to the top level.
`default_nettype none
`include "script_line_lexer_assert.svh"

module slx_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic       record_kind,
  input wire logic [3:0] token_kind,
  input wire logic [7:0] value_char,
  input wire logic       last_of_run
);
  import slx_pkg::*;

  // A result item held by a stall keeps its contents.
  `SLX_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable({record_kind, token_kind, value_char, last_of_run}))

  // Token records carry no character; value records always carry one.
  `SLX_ASSERT(a_char_by_kind, result_valid, (record_kind == REC_TOKEN) == (value_char == CH_NUL))

  // Value records belong to a string, a number or a name.
  `SLX_ASSERT(a_value_kind, result_valid && (record_kind == REC_VALUE), (token_kind == TK_STRING) || (token_kind == TK_NUMBER) || (token_kind == TK_NAME))

  // The end of line token closes the run of its item.
  `SLX_ASSERT(a_eof_last, result_valid && (record_kind == REC_TOKEN) && (token_kind == TK_EOF), last_of_run)

endmodule

bind script_line_lexer slx_checker u_slx_checker (.*);

`default_nettype wire
